FILE: design/recursive_mutex_fifo_handoff_defines.svh
// Assertion macros for the recursive mutex lock unit.
// Used by the RTL files in this folder that carry concurrent checks.
`ifndef RECURSIVE_MUTEX_FIFO_HANDOFF_DEFINES_SVH
`define RECURSIVE_MUTEX_FIFO_HANDOFF_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RMFH_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmfh: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RMFH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rmfh: next-cycle check failed");

`endif

FILE: design/rmfh_pkg.sv
// Shared types and constants for the recursive mutex lock unit.
// No dependencies; imported by rmfh_lock and recursive_mutex_fifo_handoff.
`timescale 1ns / 1ps
`default_nettype none

package rmfh_pkg;

   localparam int RMFH_QUEUE_DEPTH  = 16;
   localparam int RMFH_TASK_ID_BITS = 8;
   localparam int RMFH_LEVEL_BITS   = 16;

   typedef enum logic [0:0] {
      FUNC_ACQUIRE = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_GRANTED    = 3'd0,
      ST_QUEUED     = 3'd1,
      ST_STILL_HELD = 3'd2,
      ST_HANDED_OFF = 3'd3,
      ST_FREED      = 3'd4,
      ST_NOT_OWNER  = 3'd5,
      ST_QUEUE_FULL = 3'd6,
      ST_LEVEL_SAT  = 3'd7
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  task_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        woken_valid;
      logic [7:0]  woken_task;
      logic [15:0] lock_level;
      logic [7:0]  lock_holder;
      logic        holder_valid;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/rmfh_lock.sv
// Lock state, nesting counter and wait queue of the recursive mutex unit.
// Depends on rmfh_pkg and recursive_mutex_fifo_handoff_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "recursive_mutex_fifo_handoff_defines.svh"

module rmfh_lock
   import rmfh_pkg::*;
#(
   parameter int QUEUE_DEPTH  = RMFH_QUEUE_DEPTH,
   parameter int TASK_ID_BITS = RMFH_TASK_ID_BITS,
   parameter int LEVEL_BITS   = RMFH_LEVEL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic                    held_ff, held_in;
   logic [TASK_ID_BITS-1:0] owner_ff, owner_in;
   logic [LEVEL_BITS-1:0]   level_ff, level_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic [TASK_ID_BITS-1:0] queue_mem [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0] rd_data_ff;
   logic                    byp_ff;
   logic [TASK_ID_BITS-1:0] byp_data_ff;
   logic [TASK_ID_BITS-1:0] head_data;

   logic [TASK_ID_BITS-1:0] task_id;
   logic [LEVEL_BITS-1:0]   level_dec;
   logic                    is_owner;
   logic                    push;
   logic                    pop;
   status_type              status;
   logic                    woken_valid;
   logic [TASK_ID_BITS-1:0] woken_task;

   assign task_id   = TASK_ID_BITS'(req_data.task_id);
   assign is_owner  = held_ff && (owner_ff == task_id);
   assign level_dec = level_ff - LEVEL_BITS'(1);
   assign head_data = byp_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      held_in     = held_ff;
      owner_in    = owner_ff;
      level_in    = level_ff;
      push        = 1'b0;
      pop         = 1'b0;
      woken_valid = 1'b0;
      woken_task  = '0;
      status      = ST_NOT_OWNER;
      unique case (req_data.func)
         FUNC_ACQUIRE: begin
            priority if (!held_ff || is_owner) begin
               if (level_ff == LEVEL_MAX) begin
                  status = ST_LEVEL_SAT;
               end else begin
                  held_in  = 1'b1;
                  owner_in = task_id;
                  level_in = level_ff + LEVEL_BITS'(1);
                  status   = ST_GRANTED;
               end
            end else if (count_ff == CNT_FULL) begin
               status = ST_QUEUE_FULL;
            end else begin
               push   = 1'b1;
               status = ST_QUEUED;
            end
         end
         FUNC_RELEASE: begin
            priority if (!is_owner) begin
               status = ST_NOT_OWNER;
            end else if (level_dec != '0) begin
               level_in = level_dec;
               status   = ST_STILL_HELD;
            end else if (count_ff != '0) begin
               // hand the lock straight to the oldest waiter
               pop         = 1'b1;
               woken_valid = 1'b1;
               woken_task  = head_data;
               owner_in    = head_data;
               level_in    = LEVEL_BITS'(1);
               status      = ST_HANDED_OFF;
            end else begin
               held_in  = 1'b0;
               owner_in = '0;
               level_in = '0;
               status   = ST_FREED;
            end
         end
         default: begin
            status = ST_NOT_OWNER;
         end
      endcase
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (step && push) begin
         tail_in  = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
      end
      if (step && pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         owner_ff <= '0;
         level_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         held_ff  <= held_in;
         owner_ff <= owner_in;
         level_ff <= level_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // keep the head entry prefetched; forward a write that lands on it
   always_ff @(posedge clock) begin
      if (step && push) begin
         queue_mem[tail_ff] <= task_id;
      end
      rd_data_ff  <= queue_mem[head_in];
      byp_ff      <= step && push && (tail_ff == head_in);
      byp_data_ff <= task_id;
   end

   always_comb begin
      rsp_data              = '0;
      rsp_data.status       = status;
      rsp_data.woken_valid  = woken_valid;
      rsp_data.woken_task   = 8'(woken_task);
      rsp_data.lock_level   = 16'(level_in);
      rsp_data.lock_holder  = held_in ? 8'(owner_in) : 8'd0;
      rsp_data.holder_valid = held_in;
   end

   `RMFH_ASSERT_IMPL(a_free_level_zero, !held_ff, level_ff == '0)
   `RMFH_ASSERT_IMPL(a_count_bound, count_ff != '0, count_ff <= CNT_FULL)
   `RMFH_ASSERT_IMPL(a_empty_ptrs, count_ff == '0, head_ff == tail_ff)
   `RMFH_ASSERT_NEXT(a_handoff, step && pop,
      held_ff && level_ff == LEVEL_BITS'(1) && owner_ff == $past(head_data))

endmodule

`default_nettype wire

FILE: design/recursive_mutex_fifo_handoff.sv
// Recursive mutex lock unit with a FIFO of waiting tasks. Each request beat
// (acquire or release from a task id) yields exactly one response beat with a
// status, the woken task on hand-off, and the lock level and holder after the
// request. A request is registered on entry, evaluated against the lock state
// while it waits in the input register and lands in the response register once
// that register has room; one request per cycle is sustained while the response
// side does not stall, set by the lock update and the one-read wait queue.
// No clearing pass runs after reset; the block accepts requests right away.
// Depends on rmfh_pkg and rmfh_lock.
`timescale 1ns / 1ps
`default_nettype none

module recursive_mutex_fifo_handoff
   import rmfh_pkg::*;
#(
   parameter int QUEUE_DEPTH  = RMFH_QUEUE_DEPTH,
   parameter int TASK_ID_BITS = RMFH_TASK_ID_BITS,
   parameter int LEVEL_BITS   = RMFH_LEVEL_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   rsp_type lock_rsp;

   // move the held request into the response register when it has room
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   rmfh_lock #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS),
      .LEVEL_BITS   (LEVEL_BITS)
   ) u_lock (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_data (in_data_ff),
      .rsp_data (lock_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= lock_rsp;
      end
   end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for recursive_mutex_fifo_handoff: directed table and random
// traffic; each beat compared against a table value or an in-bench lock predictor.
// Depends on rmfh_pkg and the recursive_mutex_fifo_handoff RTL.
`timescale 1ns / 1ps

module tb_top;
   import rmfh_pkg::*;

   localparam logic [RMFH_LEVEL_BITS-1:0] LEVEL_MAX = {RMFH_LEVEL_BITS{1'b1}};
   localparam int QPTR_W        = (RMFH_QUEUE_DEPTH > 1) ? $clog2(RMFH_QUEUE_DEPTH) : 1;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int DRAIN_CYCLES  = 10;

   typedef struct {
      func_type   func;
      logic [7:0] task_id;
      bit         known;
      rsp_type    want;
   } lock_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // predicted lock state
   logic                         mx_held;
   logic [7:0]                   mx_owner;
   logic [RMFH_LEVEL_BITS-1:0]   mx_level;
   logic [7:0]                   wait_ids [RMFH_QUEUE_DEPTH];
   logic [QPTR_W-1:0]            wait_head;
   logic [QPTR_W-1:0]            wait_tail;
   int                           wait_count;

   rsp_type lock_expect [$];
   int      errors    = 0;
   bit      calm      = 1'b0;
   bit      hold_req  = 1'b0;
   bit      hold_done = 1'b0;

   recursive_mutex_fifo_handoff u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type next_lock_response(req_type r);
      rsp_type o;
      logic    is_owner;
      o = '0;
      is_owner = mx_held && (mx_owner == r.task_id);
      if (r.func == FUNC_ACQUIRE) begin
         if (!mx_held || is_owner) begin
            if (mx_level == LEVEL_MAX) begin
               o.status = ST_LEVEL_SAT;
            end else begin
               mx_held  = 1'b1;
               mx_owner = r.task_id;
               mx_level = mx_level + 1'b1;
               o.status = ST_GRANTED;
            end
         end else if (wait_count >= RMFH_QUEUE_DEPTH) begin
            o.status = ST_QUEUE_FULL;
         end else begin
            wait_ids[wait_tail] = r.task_id;
            wait_tail  = (wait_tail == QPTR_W'(RMFH_QUEUE_DEPTH - 1)) ? '0 : wait_tail + 1'b1;
            wait_count = wait_count + 1;
            o.status   = ST_QUEUED;
         end
      end else if (!is_owner) begin
         o.status = ST_NOT_OWNER;
      end else begin
         mx_level = mx_level - 1'b1;
         if (mx_level != '0) begin
            o.status = ST_STILL_HELD;
         end else if (wait_count != 0) begin
            // hand the lock straight to the head waiter
            o.woken_valid = 1'b1;
            o.woken_task  = wait_ids[wait_head];
            wait_head     = (wait_head == QPTR_W'(RMFH_QUEUE_DEPTH - 1)) ? '0 : wait_head + 1'b1;
            wait_count    = wait_count - 1;
            mx_owner      = o.woken_task;
            mx_level      = RMFH_LEVEL_BITS'(1);
            mx_held       = 1'b1;
            o.status      = ST_HANDED_OFF;
         end else begin
            mx_held  = 1'b0;
            mx_owner = '0;
            o.status = ST_FREED;
         end
      end
      o.lock_level   = mx_level;
      o.lock_holder  = mx_held ? mx_owner : 8'h00;
      o.holder_valid = mx_held;
      return o;
   endfunction

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   task automatic offer_request(req_type r, bit known, rsp_type want);
      rsp_type pred;
      while (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = next_lock_response(r);
      lock_expect.push_back(known ? want : pred);
   endtask

   task automatic offer_op(func_type f, logic [7:0] id);
      req_type r;
      r.func    = f;
      r.task_id = id;
      offer_request(r, 1'b0, '0);
   endtask

   // response side: check each accepted beat, stall at random, one long hold-off
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (lock_expect.size() == 0) begin
               $display("%0t: unexpected response beat, actual %0h", $time, rsp_data);
               errors++;
            end else begin
               want = lock_expect.pop_front();
               compare_field("status", 16'(want.status), 16'(rsp_data.status));
               compare_field("woken_valid", 16'(want.woken_valid),
                             16'(rsp_data.woken_valid));
               compare_field("woken_task", 16'(want.woken_task), 16'(rsp_data.woken_task));
               compare_field("lock_level", want.lock_level, rsp_data.lock_level);
               compare_field("lock_holder", 16'(want.lock_holder),
                             16'(rsp_data.lock_holder));
               compare_field("holder_valid", 16'(want.holder_valid),
                             16'(rsp_data.holder_valid));
            end
         end
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 11);
      end
   end

   initial begin
      lock_row_type rows [$];
      lock_row_type row;
      req_type      r;
      logic [7:0]   fill_ids [14];
      logic [7:0]   pool [4];
      int           p;

      mx_held    = 1'b0;
      mx_owner   = '0;
      mx_level   = '0;
      wait_head  = '0;
      wait_tail  = '0;
      wait_count = 0;
      fill_ids   = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                     8'h80, 8'h7F, 8'hBF, 8'hDF, 8'hEF, 8'hF7, 8'hFB};

      // directed table: free-lock release, grant, nesting, non-owner release,
      // repeated waiter, fill to full, hand-off chain
      rows.push_back('{FUNC_RELEASE, 8'h00, 1'b1,
                       '{ST_NOT_OWNER, 1'b0, 8'h00, 16'd0, 8'h00, 1'b0}});
      rows.push_back('{FUNC_ACQUIRE, 8'hFF, 1'b1,
                       '{ST_GRANTED, 1'b0, 8'h00, 16'd1, 8'hFF, 1'b1}});
      rows.push_back('{FUNC_ACQUIRE, 8'hFF, 1'b0, '0});
      rows.push_back('{FUNC_RELEASE, 8'h00, 1'b1,
                       '{ST_NOT_OWNER, 1'b0, 8'h00, 16'd2, 8'hFF, 1'b1}});
      rows.push_back('{FUNC_ACQUIRE, 8'h00, 1'b0, '0});
      rows.push_back('{FUNC_ACQUIRE, 8'h00, 1'b0, '0});
      foreach (fill_ids[i]) rows.push_back('{FUNC_ACQUIRE, fill_ids[i], 1'b0, '0});
      rows.push_back('{FUNC_ACQUIRE, 8'h5A, 1'b1,
                       '{ST_QUEUE_FULL, 1'b0, 8'h00, 16'd2, 8'hFF, 1'b1}});
      rows.push_back('{FUNC_RELEASE, 8'hFF, 1'b0, '0});
      rows.push_back('{FUNC_RELEASE, 8'hFF, 1'b0, '0});
      rows.push_back('{FUNC_RELEASE, 8'h00, 1'b0, '0});
      rows.push_back('{FUNC_RELEASE, 8'h00, 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         row       = rows[i];
         r.func    = row.func;
         r.task_id = row.task_id;
         offer_request(r, row.known, row.want);
      end

      // random traffic: mostly a small set of contending tasks, some noise
      hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // run a stretch with no idling on either side
         calm = (n >= 500 && n < 700);
         if (n % 64 == 0) begin
            foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) pool[0] = 8'h00;
            if ($urandom_range(0, 3) == 0) pool[1] = 8'hFF;
         end
         p = $urandom_range(0, 99);
         if (p < 38 && mx_held) begin
            offer_op(FUNC_RELEASE, mx_owner);
         end else if (p < 70) begin
            offer_op(FUNC_ACQUIRE, pool[$urandom_range(0, 3)]);
         end else if (p < 82 && mx_held) begin
            offer_op(FUNC_ACQUIRE, mx_owner);
         end else begin
            offer_op(func_type'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (lock_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
